### src/nfcs_pkg.sv
package nfcs_pkg;

    // Field widths of the stream items.
    localparam int COORD_W = 8;
    localparam int COST_W  = 8;
    localparam int SIZE_W  = 9;
    localparam int RAD_W   = 4;
    localparam int SEED_W  = 2;

    // Window offsets run from -15 to +15 and fit a 5-bit signed value.
    localparam int OFS_W   = 5;
    // Largest distance term is 2 * 15 * 15 = 450.
    localparam int DIST_W  = 9;
    // Largest score is 450 * 255 + 252, below 2**17.
    localparam int SCORE_W = 17;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 24;
    localparam int CFG_IDX_W = 2;

    // Cells with a cost of this value or more are treated as occupied.
    localparam logic [COST_W-1:0] BLOCKED_MIN = 8'd253;

    localparam int NUM_SEEDS = 3;

    localparam logic [SIZE_W-1:0] RST_MAP_WIDTH  = 9'd256;
    localparam logic [SIZE_W-1:0] RST_MAP_HEIGHT = 9'd256;
    localparam logic [RAD_W-1:0]  RST_RADIUS     = 4'd12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH  = 2'd0,
        CFG_MAP_HEIGHT = 2'd1,
        CFG_RADIUS     = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_index;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_QUERY = 1'b1
    } t_action;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               valid;
    } t_seed;

endpackage

### src/nearest_free_cell_search.sv
// Nearest free cell search over an 8-bit cost map held in one block RAM of
// MAP_SIDE * MAP_SIDE cells. A write transaction (tuser low) stores one cell,
// so writes may stream back to back. A query transaction (tuser high) scans
// the square window around each valid seed on the map in turn, stopping at
// the first seed whose window holds a free cell, one map read per cycle
// through the single read port of the RAM, and returns one result
// transaction. The slave side is not ready while a query is in progress.
// The map is not cleared after reset: every cell that a query can reach
// must have been written first.
module nearest_free_cell_search #(
    parameter int MAP_SIDE   = 256,
    parameter int MAX_RADIUS = 15
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // first_x, first_y, first_valid, second_x, second_y, second_valid,
    // third_x, third_y, third_valid, cell_cost, then zero padding
    input  logic [nfcs_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // action
    input  logic                                s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // goal_x, goal_y, seed_used, then zero padding
    output logic [nfcs_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // found
    output logic                                m_axis_tuser,

    input  logic                                i_cfg_we,
    input  logic [nfcs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [nfcs_pkg::SIZE_W-1:0]         i_cfg_data
);

    localparam int AW      = $clog2(MAP_SIDE * MAP_SIDE);
    localparam int SIDE_LIM_I = (MAP_SIDE < 256) ? MAP_SIDE : 256;
    localparam logic [nfcs_pkg::SIZE_W-1:0] SIDE_LIM = nfcs_pkg::SIZE_W'(SIDE_LIM_I);
    localparam logic [nfcs_pkg::RAD_W-1:0]  RAD_LIM  =
        (MAX_RADIUS < 15) ? nfcs_pkg::RAD_W'(MAX_RADIUS) : nfcs_pkg::RAD_W'(15);

    localparam int CW  = nfcs_pkg::COORD_W;
    localparam int OW  = nfcs_pkg::OFS_W;
    localparam int DW  = nfcs_pkg::DIST_W;
    localparam int SW  = nfcs_pkg::SCORE_W;
    localparam int PW  = CW + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_SCAN,
        ST_FLUSH,
        ST_DECIDE,
        ST_DONE
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [nfcs_pkg::SIZE_W-1:0] r_map_width;
    logic [nfcs_pkg::SIZE_W-1:0] r_map_height;
    logic [nfcs_pkg::RAD_W-1:0]  r_radius;

    // Seeds of the running query; slot 0 is always the one under test.
    nfcs_pkg::t_seed r_seed [nfcs_pkg::NUM_SEEDS];
    logic [nfcs_pkg::SEED_W-1:0] r_k;

    // Scan position.
    logic [CW-1:0]        r_cx;
    logic [CW-1:0]        r_cy;
    logic signed [OW-1:0] r_dx;
    logic signed [OW-1:0] r_dy;

    // Tag of the read in flight.
    logic          r_p_vld;
    logic [CW-1:0] r_p_x;
    logic [CW-1:0] r_p_y;
    logic [DW-1:0] r_p_dist;

    // Best cell of the current seed.
    logic          r_hit;
    logic [SW-1:0] r_best_score;
    logic [CW-1:0] r_best_x;
    logic [CW-1:0] r_best_y;

    // Pending result and output register.
    logic                        r_res_found;
    logic [CW-1:0]               r_res_x;
    logic [CW-1:0]               r_res_y;
    logic [nfcs_pkg::SEED_W-1:0] r_res_seed;
    logic                        r_m_valid;
    logic                        r_m_found;
    logic [CW-1:0]               r_m_x;
    logic [CW-1:0]               r_m_y;
    logic [nfcs_pkg::SEED_W-1:0] r_m_seed;

    // Effective map size and radius.
    logic [nfcs_pkg::SIZE_W-1:0] eff_w;
    logic [nfcs_pkg::SIZE_W-1:0] eff_h;
    logic [nfcs_pkg::RAD_W-1:0]  eff_r;
    logic signed [OW-1:0]        pos_r;
    logic signed [OW-1:0]        neg_r;

    assign eff_w = (r_map_width  > SIDE_LIM) ? SIDE_LIM : r_map_width;
    assign eff_h = (r_map_height > SIDE_LIM) ? SIDE_LIM : r_map_height;
    assign eff_r = (r_radius > RAD_LIM) ? RAD_LIM : r_radius;
    assign pos_r = $signed({1'b0, eff_r});
    assign neg_r = -pos_r;

    // Input item fields.
    logic                        in_accept;
    logic                        in_query;
    logic [CW-1:0]               in_x;
    logic [CW-1:0]               in_y;
    logic [nfcs_pkg::COST_W-1:0] in_cost;
    nfcs_pkg::t_seed             in_seed [nfcs_pkg::NUM_SEEDS];

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_query  = (s_axis_tuser == nfcs_pkg::ACT_QUERY);
    assign in_x      = s_axis_tdata[7:0];
    assign in_y      = s_axis_tdata[15:8];
    assign in_cost   = s_axis_tdata[58:51];

    assign in_seed[0] = '{x: s_axis_tdata[7:0],   y: s_axis_tdata[15:8],
                          valid: s_axis_tdata[16]};
    assign in_seed[1] = '{x: s_axis_tdata[24:17], y: s_axis_tdata[32:25],
                          valid: s_axis_tdata[33]};
    assign in_seed[2] = '{x: s_axis_tdata[41:34], y: s_axis_tdata[49:42],
                          valid: s_axis_tdata[50]};

    // Map RAM access.
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [AW-1:0]               ram_raddr;
    logic [nfcs_pkg::COST_W-1:0] ram_rdata;

    assign ram_we    = in_accept && !in_query &&
                       (32'(in_x) < 32'(MAP_SIDE)) && (32'(in_y) < 32'(MAP_SIDE));
    assign ram_waddr = AW'(in_y) * AW'(MAP_SIDE) + AW'(in_x);

    // Cell under the scan position.
    logic signed [PW-1:0] mx;
    logic signed [PW-1:0] my;
    logic                 in_map;
    logic signed [2*OW-1:0] sq_x;
    logic signed [2*OW-1:0] sq_y;
    logic [DW-1:0]        dist_sq;
    logic                 last_col;
    logic                 last_cell;

    assign mx = $signed({2'b00, r_cx}) + PW'(r_dx);
    assign my = $signed({2'b00, r_cy}) + PW'(r_dy);
    assign in_map = !mx[PW-1] && !my[PW-1] &&
                    (mx < $signed({1'b0, eff_w})) && (my < $signed({1'b0, eff_h}));
    assign ram_raddr = AW'(my[CW-1:0]) * AW'(MAP_SIDE) + AW'(mx[CW-1:0]);

    assign sq_x    = r_dx * r_dx;
    assign sq_y    = r_dy * r_dy;
    assign dist_sq = DW'(sq_x) + DW'(sq_y);

    assign last_col  = (r_dx == pos_r);
    assign last_cell = last_col && (r_dy == pos_r);

    // Score of the cell whose cost has just come back: distance times 255
    // plus cost.
    logic [SW-1:0] cand_score;
    logic          cand_take;

    assign cand_score = SW'({r_p_dist, 8'h00}) - SW'(r_p_dist) + SW'(ram_rdata);
    assign cand_take  = r_p_vld && (ram_rdata < nfcs_pkg::BLOCKED_MIN) &&
                        (!r_hit || (cand_score < r_best_score));

    // Slot 0 seed qualifies when valid and on the map.
    logic seed_ok;
    assign seed_ok = r_seed[0].valid &&
                     ({1'b0, r_seed[0].x} < eff_w) && ({1'b0, r_seed[0].y} < eff_h);

    logic out_free;
    assign out_free = !r_m_valid || m_axis_tready;

    nfcs_ram #(
        .WIDTH(nfcs_pkg::COST_W),
        .DEPTH(MAP_SIDE * MAP_SIDE)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (in_cost),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= nfcs_pkg::RST_MAP_WIDTH;
            r_map_height <= nfcs_pkg::RST_MAP_HEIGHT;
            r_radius     <= nfcs_pkg::RST_RADIUS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                nfcs_pkg::CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                nfcs_pkg::CFG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                nfcs_pkg::CFG_RADIUS:     r_radius     <= i_cfg_data[nfcs_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_p_vld      <= 1'b0;
            r_hit        <= 1'b0;
            r_best_score <= '1;
            r_best_x     <= '0;
            r_best_y     <= '0;
            r_m_valid    <= 1'b0;
            r_k          <= '0;
        end else begin
            r_p_vld <= (r_state == ST_SCAN) && in_map;

            if ((r_state == ST_DONE) && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            if (cand_take) begin
                r_hit        <= 1'b1;
                r_best_score <= cand_score;
                r_best_x     <= r_p_x;
                r_best_y     <= r_p_y;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_accept && in_query) begin
                        for (int i = 0; i < nfcs_pkg::NUM_SEEDS; i++) begin
                            r_seed[i] <= in_seed[i];
                        end
                        r_k     <= '0;
                        r_state <= ST_SEED;
                    end
                end
                ST_SEED: begin
                    if (r_k == nfcs_pkg::SEED_W'(nfcs_pkg::NUM_SEEDS)) begin
                        r_res_found <= 1'b0;
                        r_res_x     <= '0;
                        r_res_y     <= '0;
                        r_res_seed  <= '0;
                        r_state     <= ST_DONE;
                    end else if (seed_ok) begin
                        r_cx         <= r_seed[0].x;
                        r_cy         <= r_seed[0].y;
                        r_dx         <= neg_r;
                        r_dy         <= neg_r;
                        r_hit        <= 1'b0;
                        r_best_score <= '1;
                        r_best_x     <= '0;
                        r_best_y     <= '0;
                        r_state      <= ST_SCAN;
                    end else begin
                        r_seed[0] <= r_seed[1];
                        r_seed[1] <= r_seed[2];
                        r_k       <= r_k + 1'b1;
                    end
                end
                ST_SCAN: begin
                    r_p_x    <= mx[CW-1:0];
                    r_p_y    <= my[CW-1:0];
                    r_p_dist <= dist_sq;
                    if (last_cell) begin
                        r_state <= ST_FLUSH;
                    end else if (last_col) begin
                        r_dx <= neg_r;
                        r_dy <= r_dy + 1'b1;
                    end else begin
                        r_dx <= r_dx + 1'b1;
                    end
                end
                ST_FLUSH: begin
                    // The last read is scored in this cycle.
                    r_state <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (r_hit) begin
                        r_res_found <= 1'b1;
                        r_res_x     <= r_best_x;
                        r_res_y     <= r_best_y;
                        r_res_seed  <= r_k;
                        r_state     <= ST_DONE;
                    end else begin
                        r_seed[0] <= r_seed[1];
                        r_seed[1] <= r_seed[2];
                        r_k       <= r_k + 1'b1;
                        r_state   <= ST_SEED;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_m_found <= r_res_found;
                        r_m_x     <= r_res_x;
                        r_m_y     <= r_res_y;
                        r_m_seed  <= r_res_seed;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_found;
    assign m_axis_tdata  = {6'd0, r_m_seed, r_m_y, r_m_x};

    // A read tag is only ever produced by a scan cycle.
    a_tag_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_vld |-> $past(r_state == ST_SCAN))
        else $error("read tag without a preceding scan cycle");

    // A result that reports nothing found carries all-zero fields.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !r_m_found) |-> (r_m_x == '0 && r_m_y == '0 && r_m_seed == '0))
        else $error("not-found result with non-zero fields");

    // Only three seeds exist.
    a_seed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_m_seed != 2'd3))
        else $error("seed index out of range");

    // Once a cell is held, its score is below the empty marker.
    a_hit_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> (r_best_score != '1))
        else $error("best cell held with an empty score");

    // Scan offsets stay inside the window.
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_dx <= pos_r && r_dx >= neg_r &&
                                  r_dy <= pos_r && r_dy >= neg_r))
        else $error("scan offset outside the window");

endmodule

### src/nfcs_ram.sv
module nfcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### test/tb.sv
`timescale 1ns / 100ps

localparam int MAP_SIDE   = 256;
localparam int MAX_RADIUS = 15;

// Seeds in priority order: index 0 is the first seed.
typedef nfcs_pkg::t_seed [nfcs_pkg::NUM_SEEDS-1:0] t_seed_set;

typedef struct packed {
    bit                         found;
    bit [nfcs_pkg::COORD_W-1:0] goal_x;
    bit [nfcs_pkg::COORD_W-1:0] goal_y;
    bit [nfcs_pkg::SEED_W-1:0]  seed_used;
} t_goal;

class goal_scoreboard;
    bit [nfcs_pkg::COST_W-1:0] cost_map [0:MAP_SIDE*MAP_SIDE-1];
    bit [nfcs_pkg::SIZE_W-1:0] map_width;
    bit [nfcs_pkg::SIZE_W-1:0] map_height;
    bit [nfcs_pkg::RAD_W-1:0]  radius;
    t_goal                     expected_goals [$];
    int                        errors;

    function new();
        map_width  = nfcs_pkg::RST_MAP_WIDTH;
        map_height = nfcs_pkg::RST_MAP_HEIGHT;
        radius     = nfcs_pkg::RST_RADIUS;
        errors     = 0;
    endfunction

    // Number of rows or columns that are really on the map.
    function int span(bit [nfcs_pkg::SIZE_W-1:0] v);
        if (v > MAP_SIDE) begin
            return MAP_SIDE;
        end
        return int'(v);
    endfunction

    function void set_register(nfcs_pkg::t_cfg_index idx, bit [nfcs_pkg::SIZE_W-1:0] val);
        case (idx)
            nfcs_pkg::CFG_MAP_WIDTH:  map_width  = val;
            nfcs_pkg::CFG_MAP_HEIGHT: map_height = val;
            nfcs_pkg::CFG_RADIUS:     radius     = val[nfcs_pkg::RAD_W-1:0];
            default: ;
        endcase
    endfunction

    function t_goal nearest_free_goal(t_seed_set seeds);
        t_goal g;
        int    w, h, r, k, dx, dy, mx, my, score, best;
        bit    hit;
        bit [nfcs_pkg::COST_W-1:0] c;
        g = '0;
        w = span(map_width);
        h = span(map_height);
        r = (radius > MAX_RADIUS) ? MAX_RADIUS : int'(radius);
        for (k = 0; k < nfcs_pkg::NUM_SEEDS; k++) begin
            if (!seeds[k].valid || seeds[k].x >= w || seeds[k].y >= h) begin
                continue;
            end
            hit  = 1'b0;
            best = 0;
            for (dy = -r; dy <= r; dy++) begin
                for (dx = -r; dx <= r; dx++) begin
                    mx = int'(seeds[k].x) + dx;
                    my = int'(seeds[k].y) + dy;
                    if (mx < 0 || my < 0 || mx >= w || my >= h) begin
                        continue;
                    end
                    c = cost_map[my * MAP_SIDE + mx];
                    if (c >= nfcs_pkg::BLOCKED_MIN) begin
                        continue;
                    end
                    score = (dx * dx + dy * dy) * 255 + int'(c);
                    // Strict comparison keeps the earliest cell on a tie.
                    if (!hit || score < best) begin
                        hit      = 1'b1;
                        best     = score;
                        g.goal_x = mx[nfcs_pkg::COORD_W-1:0];
                        g.goal_y = my[nfcs_pkg::COORD_W-1:0];
                    end
                end
            end
            if (hit) begin
                g.found     = 1'b1;
                g.seed_used = k[nfcs_pkg::SEED_W-1:0];
                return g;
            end
        end
        return '0;
    endfunction

    function void note_transaction(nfcs_pkg::t_action act, t_seed_set seeds,
                                   logic [nfcs_pkg::COST_W-1:0] cost);
        if (act == nfcs_pkg::ACT_WRITE) begin
            cost_map[{seeds[0].y, seeds[0].x}] = cost;
        end else begin
            expected_goals = {expected_goals, nearest_free_goal(seeds)};
        end
    endfunction

    function void check_goal(logic found, logic [nfcs_pkg::M_TDATA_W-1:0] data);
        t_goal want;
        if (expected_goals.size() == 0) begin
            $error("result with no query outstanding: found %0d data %h", found, data);
            errors++;
            return;
        end
        want = expected_goals.pop_front();
        if (found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found);
            errors++;
        end
        if (data[7:0] !== want.goal_x) begin
            $error("goal_x: expected %0d, actual %0d", want.goal_x, data[7:0]);
            errors++;
        end
        if (data[15:8] !== want.goal_y) begin
            $error("goal_y: expected %0d, actual %0d", want.goal_y, data[15:8]);
            errors++;
        end
        if (data[17:16] !== want.seed_used) begin
            $error("seed_used: expected %0d, actual %0d", want.seed_used, data[17:16]);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int CYCLE_LIMIT     = 5_000_000;
    localparam int ITEMS_PER_PHASE = 43;
    localparam int NUM_PHASES      = 7;
    localparam int CLUSTER_LO      = 100;
    localparam int CLUSTER_HI      = 139;
    localparam int WALL_X          = 30;
    localparam int WALL_Y          = 200;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [nfcs_pkg::S_TDATA_W-1:0]  s_axis_tdata;
    logic                            s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [nfcs_pkg::M_TDATA_W-1:0]  m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            i_cfg_we;
    logic [nfcs_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [nfcs_pkg::SIZE_W-1:0]     i_cfg_data;

    goal_scoreboard sb;
    bit             written [0:MAP_SIDE*MAP_SIDE-1];
    int             send_gap_pct = 0;
    int             recv_gap_pct = 0;
    int unsigned    cycles = 0;

    nearest_free_cell_search #(
        .MAP_SIDE  (MAP_SIDE),
        .MAX_RADIUS(MAX_RADIUS)
    ) DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_goal(m_axis_tuser, m_axis_tdata);
        end
    end

    function automatic nfcs_pkg::t_seed make_seed(int x, int y, bit v);
        nfcs_pkg::t_seed s;
        s.x     = x[nfcs_pkg::COORD_W-1:0];
        s.y     = y[nfcs_pkg::COORD_W-1:0];
        s.valid = v;
        return s;
    endfunction

    function automatic nfcs_pkg::t_seed noise_seed(bit v);
        return make_seed($urandom_range(255), $urandom_range(255), v);
    endfunction

    function automatic t_seed_set seed_set(nfcs_pkg::t_seed s0, nfcs_pkg::t_seed s1,
                                           nfcs_pkg::t_seed s2);
        t_seed_set t;
        t[0] = s0;
        t[1] = s1;
        t[2] = s2;
        return t;
    endfunction

    function automatic logic [nfcs_pkg::COST_W-1:0] random_cost();
        case ($urandom_range(3))
            0, 1: begin
                return nfcs_pkg::COST_W'($urandom_range(nfcs_pkg::BLOCKED_MIN - 1, 0));
            end
            2: begin
                return nfcs_pkg::COST_W'($urandom_range(255, nfcs_pkg::BLOCKED_MIN));
            end
            default: return nfcs_pkg::COST_W'($urandom_range(255));
        endcase
    endfunction

    function automatic int border_coord(int span_v);
        case ($urandom_range(3))
            0:       return 0;
            1:       return 255;
            2:       return (span_v > 0) ? span_v - 1 : 0;
            default: return $urandom_range(CLUSTER_HI, CLUSTER_LO);
        endcase
    endfunction

    // Most seeds land in one cluster so that their windows overlap and the
    // map that has to be written stays small.
    function automatic nfcs_pkg::t_seed random_seed();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            return make_seed($urandom_range(CLUSTER_HI, CLUSTER_LO),
                             $urandom_range(CLUSTER_HI, CLUSTER_LO), 1'b1);
        end else if (pick < 62) begin
            return make_seed(border_coord(sb.span(sb.map_width)),
                             border_coord(sb.span(sb.map_height)), 1'b1);
        end else if (pick < 70) begin
            return make_seed(WALL_X, WALL_Y, 1'b1);
        end
        return noise_seed(1'b0);
    endfunction

    function automatic logic [nfcs_pkg::S_TDATA_W-1:0] pack_item(
        t_seed_set seeds, logic [nfcs_pkg::COST_W-1:0] cost);
        // Five bits of zero padding above the cost.
        return {5'd0, cost,
                seeds[2].valid, seeds[2].y, seeds[2].x,
                seeds[1].valid, seeds[1].y, seeds[1].x,
                seeds[0].valid, seeds[0].y, seeds[0].x};
    endfunction

    function automatic void set_idling(int mode);
        case (mode)
            0: begin
                send_gap_pct = 7;
                recv_gap_pct = 61;
            end
            1: begin
                send_gap_pct = 61;
                recv_gap_pct = 7;
            end
            default: begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
        endcase
    endfunction

    // Starts and ends just after a falling edge. tvalid is left high so that
    // back-to-back transactions need no gap.
    task automatic send_item(nfcs_pkg::t_action act, t_seed_set seeds,
                             logic [nfcs_pkg::COST_W-1:0] cost);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  = pack_item(seeds, cost);
        s_axis_tuser  = act;
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_transaction(act, seeds, cost);
        if (act == nfcs_pkg::ACT_WRITE) begin
            written[{seeds[0].y, seeds[0].x}] = 1'b1;
        end
        @(negedge i_clk);
    endtask

    task automatic write_cell(int x, int y, logic [nfcs_pkg::COST_W-1:0] cost);
        t_seed_set seeds;
        seeds = seed_set(make_seed(x, y, 1'($urandom_range(1))),
                         noise_seed(1'($urandom_range(1))),
                         noise_seed(1'($urandom_range(1))));
        send_item(nfcs_pkg::ACT_WRITE, seeds, cost);
    endtask

    // Writes every cell of the seed's window that is on the map and has not
    // been written yet, so that a query never reads an undefined cell.
    task automatic ensure_window(int x, int y, bit blocked);
        int w, h, r, mx, my;
        w = sb.span(sb.map_width);
        h = sb.span(sb.map_height);
        r = int'(sb.radius);
        if (x >= w || y >= h) begin
            return;
        end
        for (my = y - r; my <= y + r; my++) begin
            for (mx = x - r; mx <= x + r; mx++) begin
                if (mx >= 0 && my >= 0 && mx < w && my < h &&
                    !written[my * MAP_SIDE + mx]) begin
                    write_cell(mx, my,
                               blocked ? nfcs_pkg::COST_W'($urandom_range(255,
                                                           nfcs_pkg::BLOCKED_MIN))
                                       : random_cost());
                end
            end
        end
    endtask

    task automatic run_query(t_seed_set seeds);
        int k;
        for (k = 0; k < nfcs_pkg::NUM_SEEDS; k++) begin
            if (seeds[k].valid) begin
                ensure_window(seeds[k].x, seeds[k].y, 1'b0);
            end
        end
        send_item(nfcs_pkg::ACT_QUERY, seeds, random_cost());
    endtask

    task automatic write_register(nfcs_pkg::t_cfg_index idx, int val);
        s_axis_tvalid = 1'b0;
        i_cfg_we      = 1'b1;
        i_cfg_index   = idx;
        i_cfg_data    = val[nfcs_pkg::SIZE_W-1:0];
        @(posedge i_clk);
        sb.set_register(idx, val[nfcs_pkg::SIZE_W-1:0]);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic configure(int w, int h, int r);
        write_register(nfcs_pkg::CFG_MAP_WIDTH, w);
        write_register(nfcs_pkg::CFG_MAP_HEIGHT, h);
        write_register(nfcs_pkg::CFG_RADIUS, r);
    endtask

    // Waits for every outstanding result, then lets a write still in flight
    // finish before anything else touches the block.
    task automatic settle(int extra);
        s_axis_tvalid = 1'b0;
        while (sb.expected_goals.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    initial begin
        int phase, n;
        sb            = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = nfcs_pkg::ACT_WRITE;
        i_cfg_we      = 1'b0;
        i_cfg_index   = nfcs_pkg::CFG_MAP_WIDTH;
        i_cfg_data    = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, with the settings left by reset.
        set_idling(0);
        write_cell(255, 255, 8'd0);
        run_query(seed_set(make_seed(255, 255, 1'b1), noise_seed(1'b0), noise_seed(1'b0)));

        // Blocked centre with two equal neighbours: the one in the earlier row wins.
        write_cell(0, 0, 8'd255);
        write_cell(1, 0, 8'd10);
        write_cell(0, 1, 8'd10);
        ensure_window(0, 0, 1'b1);
        run_query(seed_set(make_seed(0, 0, 1'b1), noise_seed(1'b0), noise_seed(1'b0)));

        // The highest free cost beside the lowest blocked cost, around a blocked centre.
        write_cell(200, 30, 8'd254);
        write_cell(201, 30, nfcs_pkg::BLOCKED_MIN);
        write_cell(200, 31, nfcs_pkg::BLOCKED_MIN - 8'd1);
        ensure_window(200, 30, 1'b1);
        run_query(seed_set(make_seed(200, 30, 1'b1), noise_seed(1'b0), noise_seed(1'b0)));

        // A window with nothing free passes the search on to the next seed.
        ensure_window(WALL_X, WALL_Y, 1'b1);
        run_query(seed_set(make_seed(WALL_X, WALL_Y, 1'b1), make_seed(0, 0, 1'b1),
                           noise_seed(1'b0)));
        run_query(seed_set(noise_seed(1'b0), make_seed(WALL_X, WALL_Y, 1'b1),
                           make_seed(255, 255, 1'b1)));
        run_query(seed_set(noise_seed(1'b0), noise_seed(1'b0), noise_seed(1'b0)));
        run_query(seed_set(make_seed(WALL_X, WALL_Y, 1'b1), noise_seed(1'b0),
                           make_seed(WALL_X, WALL_Y, 1'b1)));
        write_cell(0, 255, 8'd0);
        write_cell(255, 0, 8'd128);
        run_query(seed_set(make_seed(0, 255, 1'b1), make_seed(255, 0, 1'b1),
                           noise_seed(1'b1)));

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            settle(10);
            set_idling(phase < 2 ? 0 : (phase < 4 ? 1 : 2));
            case (phase)
                0: ;
                1: configure(1, 1, 0);
                2: configure(256, 256, 15);
                3: configure(0, 300, 5);
                4: begin
                    configure(511, 40, 7);
                    write_register(nfcs_pkg::CFG_UNUSED, $urandom_range(511));
                end
                5: configure(140, 256, 1);
                default: configure(256, 256, 12);
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(99) < 30) begin
                    if ($urandom_range(1) == 0) begin
                        write_cell($urandom_range(CLUSTER_HI, CLUSTER_LO),
                                   $urandom_range(CLUSTER_HI, CLUSTER_LO), random_cost());
                    end else begin
                        write_cell($urandom_range(255), $urandom_range(255), random_cost());
                    end
                end else begin
                    run_query(seed_set(random_seed(), random_seed(), random_seed()));
                end
            end
        end

        settle(20);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

### filelist.f
src/nfcs_pkg.sv
src/nfcs_ram.sv
src/nearest_free_cell_search.sv
test/tb.sv
